// ----- hw/rtl/bfpa_pkg.sv -----
// Shared types and codes of the best-fit partition allocator.
package bfpa_pkg;

  localparam int INDEX_W     = 4;
  localparam int SIZE_W      = 16;
  localparam int OWNER_W     = 8;
  localparam int COUNT_W     = 5;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RELEASE = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_BIG = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PARTITION_COUNT = 2'd0,
    REG_SECTION_LIMIT   = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [INDEX_W-1:0] partition_index;
    logic [SIZE_W-1:0]  base_address;
    logic [SIZE_W-1:0]  request_size;
    logic [OWNER_W-1:0] owner_pid;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] granted_index;
    logic [SIZE_W-1:0]  granted_base;
    logic [SIZE_W-1:0]  granted_size;
    logic [OWNER_W-1:0] prior_owner;
  } rsp_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]      cfg_value;
  } cfg_t;

endpackage

// ----- hw/rtl/bfpa_chan_if.sv -----
// Valid/ready channel carrying one word of a given payload type.
interface bfpa_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bfpa_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module bfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/best_fit_partition_allocator.sv -----
// Top level of the best-fit fixed-partition allocator.
//
//   port  direction  payload  role
//   req   in         req_t    load, allocate or release request words
//   rsp   out        rsp_t    one result word per request
//   cfg   in         cfg_t    register writes (partition_count, section_limit)
//
// A load goes straight to its result, a release in range first reads its entry
// and an allocation scans min(partition_count, PARTITIONS) entries. The table
// RAM has one read port and the scan reads one entry per cycle. Reset clears
// in_use and partition_count and sets section_limit to all ones; base, size
// and owner are not cleared. A new request is taken while the previous result
// still waits in the output register; a stalled result holds the sequencer.
module best_fit_partition_allocator #(
  parameter int PARTITIONS = 16,
  parameter int ADDR_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  bfpa_chan_if.sink   req,
  bfpa_chan_if.source rsp,
  bfpa_chan_if.sink   cfg
);
  import bfpa_pkg::*;

  localparam int IDX_W  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W  = $clog2(PARTITIONS + 1);
  localparam int CMP_W  = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;
  localparam int WORD_W = 2 * ADDR_BITS + OWNER_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_RESP} state_t;

  state_t               state;
  logic [COUNT_W-1:0]   partition_count;
  logic [SIZE_W-1:0]    section_limit;
  logic [INDEX_W-1:0]   ridx;
  logic [SIZE_W-1:0]    rsize;
  logic [OWNER_W-1:0]   rowner;
  logic [CNT_W-1:0]     scan_addr;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [ADDR_BITS-1:0] largest;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [ADDR_BITS-1:0] best_base;
  logic [ADDR_BITS-1:0] best_size;
  logic [PARTITIONS-1:0] in_use;
  rsp_t                 res;
  rsp_t                 out_data;
  logic                 out_valid;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  logic [CNT_W-1:0]     cnt_eff;
  logic                 idx_ok;
  logic                 issue;
  logic                 scan_done;
  logic                 too_big;
  logic                 grant;
  logic                 fits;
  logic                 load_out;
  logic [ADDR_BITS-1:0] d_base;
  logic [ADDR_BITS-1:0] d_size;
  logic [OWNER_W-1:0]   d_owner;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // A count above the table depth saturates to the depth.
  assign cnt_eff = (int'(partition_count) > PARTITIONS) ? CNT_W'(PARTITIONS)
                                                        : CNT_W'(partition_count);
  assign idx_ok  = int'(req.data.partition_index) < PARTITIONS;

  assign d_base  = ram_rdata[WORD_W-1 -: ADDR_BITS];
  assign d_size  = ram_rdata[ADDR_BITS+OWNER_W-1 -: ADDR_BITS];
  assign d_owner = ram_rdata[OWNER_W-1:0];

  assign issue     = (state == S_SCAN) && (scan_addr < cnt_eff);
  assign scan_done = (state == S_SCAN) && !issue && !rd_vld;
  assign too_big   = (rsize > section_limit) || (CMP_W'(rsize) > CMP_W'(largest));
  assign grant     = scan_done && !too_big && found;
  assign fits      = !in_use[rd_idx] && (CMP_W'(d_size) >= CMP_W'(rsize)) &&
                     (!found || (d_size < best_size));
  assign load_out  = (state == S_RESP) && (!out_valid || rsp.ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(req.data.partition_index);
    ram_wdata = {ADDR_BITS'(req.data.base_address), ADDR_BITS'(req.data.request_size),
                 OWNER_W'(0)};
    ram_raddr = IDX_W'(req.data.partition_index);
    if (state == S_IDLE) begin
      ram_we = req.valid && (req.data.req_type == REQ_LOAD) && idx_ok;
    end
    if (issue) begin
      ram_raddr = scan_addr[IDX_W-1:0];
    end
    if (grant) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = {best_base, best_size, rowner};
    end
  end

  bfpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PARTITIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      partition_count <= '0;
      section_limit   <= '1;
      rd_vld          <= 1'b0;
      found           <= 1'b0;
      in_use          <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.cfg_index)
          REG_PARTITION_COUNT: partition_count <= cfg.data.cfg_value[COUNT_W-1:0];
          REG_SECTION_LIMIT:   section_limit   <= cfg.data.cfg_value;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      rd_vld <= issue;
      rd_idx <= scan_addr[IDX_W-1:0];

      // Largest size and best fit are gathered in the same pass.
      if (rd_vld) begin
        if (d_size > largest) begin
          largest <= d_size;
        end
        if (fits) begin
          found     <= 1'b1;
          best_idx  <= rd_idx;
          best_base <= d_base;
          best_size <= d_size;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            ridx      <= req.data.partition_index;
            rsize     <= req.data.request_size;
            rowner    <= req.data.owner_pid;
            scan_addr <= '0;
            largest   <= '0;
            found     <= 1'b0;
            unique case (req.data.req_type)
              REQ_LOAD: begin
                res <= '{status:        ST_OK,
                         granted_index: req.data.partition_index,
                         granted_base:  idx_ok ? SIZE_W'(ADDR_BITS'(req.data.base_address))
                                               : '0,
                         granted_size:  idx_ok ? SIZE_W'(ADDR_BITS'(req.data.request_size))
                                               : '0,
                         prior_owner:   '0};
                if (idx_ok) begin
                  in_use[IDX_W'(req.data.partition_index)] <= 1'b0;
                end
                state <= S_RESP;
              end
              REQ_ALLOC: begin
                state <= S_SCAN;
              end
              REQ_RELEASE: begin
                res <= '{status:        ST_OK,
                         granted_index: req.data.partition_index,
                         granted_base:  '0,
                         granted_size:  '0,
                         prior_owner:   '0};
                state <= idx_ok ? S_READ : S_RESP;
              end
              default: begin
                res   <= '0;
                state <= S_RESP;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end
          if (scan_done) begin
            if (too_big) begin
              res <= '{status: ST_TOO_BIG, granted_index: '0, granted_base: '0,
                       granted_size: '0, prior_owner: '0};
            end else if (!found) begin
              res <= '{status: ST_FULL, granted_index: '0, granted_base: '0,
                       granted_size: '0, prior_owner: '0};
            end else begin
              res <= '{status:        ST_OK,
                       granted_index: INDEX_W'(best_idx),
                       granted_base:  SIZE_W'(best_base),
                       granted_size:  SIZE_W'(best_size),
                       prior_owner:   '0};
              in_use[best_idx] <= 1'b1;
            end
            state <= S_RESP;
          end
        end
        S_READ: begin
          res.granted_base <= SIZE_W'(d_base);
          res.granted_size <= SIZE_W'(d_size);
          res.prior_owner  <= d_owner;
          in_use[IDX_W'(ridx)] <= 1'b0;
          state <= S_RESP;
        end
        S_RESP: begin
          if (load_out) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_addr <= cnt_eff))
    else $error("scan address ran past the partition count");

  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_vld)
    else $error("table read still in flight while idle");

  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    found |-> (CMP_W'(best_size) >= CMP_W'(rsize)))
    else $error("chosen partition is smaller than the request");

  a_best_le_largest: assert property (@(posedge clk) disable iff (rst)
    found |-> (best_size <= largest))
    else $error("chosen partition exceeds the largest size seen");

endmodule

// ----- bench/best_fit_partition_allocator_tb.sv -----
// Self-checking testbench for the best-fit partition allocator with random flow control.
`timescale 1ns / 100ps

module best_fit_partition_allocator_tb;
  import bfpa_pkg::*;

  localparam int PARTS        = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int LONG_HOLD    = 400;
  localparam int NUM_PHASES   = 7;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic clk;
  logic rst;

  bfpa_chan_if #(.T(req_t)) req_if ();
  bfpa_chan_if #(.T(rsp_t)) rsp_if ();
  bfpa_chan_if #(.T(cfg_t)) cfg_if ();

  best_fit_partition_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predicted copy of the partition table and the registers.
  logic [15:0] tbl_base  [PARTS];
  logic [15:0] tbl_size  [PARTS];
  logic        tbl_busy  [PARTS];
  logic [7:0]  tbl_owner [PARTS];
  logic [4:0]  cfg_count;
  logic [15:0] cfg_limit;

  // Sizes as the stimulus has loaded them, used to aim allocations at real partitions.
  logic [15:0] plan_size [PARTS];

  req_t pending_words [$];
  rsp_t grants_due [$];

  int words_queued;
  int words_taken;
  int cycle_count;
  int errors;
  int n_ok;
  int n_too_big;
  int n_full;
  int settings_used;
  logic req_accepted;
  logic cfg_accepted;

  int burst_left;
  int gap_left;
  int hold_requests;
  int hold_served;
  int hold_left;
  int stall_mode;
  int mode_left;
  int stall_phase;

  function automatic rsp_t predict_grant(input req_t r);
    rsp_t        res;
    int          n;
    logic [15:0] largest;
    logic        found;
    int          pick;
    res = '0;
    n = (cfg_count > PARTS) ? PARTS : int'(cfg_count);
    case (r.req_type)
      REQ_LOAD: begin
        tbl_base[r.partition_index]  = r.base_address;
        tbl_size[r.partition_index]  = r.request_size;
        tbl_busy[r.partition_index]  = 1'b0;
        tbl_owner[r.partition_index] = '0;
        res.status        = ST_OK;
        res.granted_index = r.partition_index;
        res.granted_base  = r.base_address;
        res.granted_size  = r.request_size;
      end
      REQ_ALLOC: begin
        largest = '0;
        for (int i = 0; i < n; i++)
          if (tbl_size[i] > largest) largest = tbl_size[i];
        if (r.request_size > cfg_limit || r.request_size > largest) begin
          res.status = ST_TOO_BIG;
        end else begin
          found = 1'b0;
          pick  = 0;
          // Strictly smaller wins, so ties stay with the lower index.
          for (int i = 0; i < n; i++)
            if (!tbl_busy[i] && tbl_size[i] >= r.request_size &&
                (!found || tbl_size[i] < tbl_size[pick])) begin
              found = 1'b1;
              pick  = i;
            end
          if (!found) begin
            res.status = ST_FULL;
          end else begin
            tbl_busy[pick]    = 1'b1;
            tbl_owner[pick]   = r.owner_pid;
            res.status        = ST_OK;
            res.granted_index = pick[3:0];
            res.granted_base  = tbl_base[pick];
            res.granted_size  = tbl_size[pick];
          end
        end
      end
      REQ_RELEASE: begin
        tbl_busy[r.partition_index] = 1'b0;
        res.status        = ST_OK;
        res.granted_index = r.partition_index;
        res.granted_base  = tbl_base[r.partition_index];
        res.granted_size  = tbl_size[r.partition_index];
        res.prior_owner   = tbl_owner[r.partition_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] kind, input logic [3:0] idx,
                                    input logic [15:0] base, input logic [15:0] size,
                                    input logic [7:0] owner);
    req_t r;
    r.req_type        = kind;
    r.partition_index = idx;
    r.base_address    = base;
    r.request_size    = size;
    r.owner_pid       = owner;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int          roll;
    int          d;
    logic [15:0] s;
    r.partition_index = 4'($urandom_range(0, PARTS - 1));
    r.base_address    = 16'($urandom);
    r.request_size    = 16'($urandom);
    r.owner_pid       = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      r.req_type = REQ_ALLOC;
      case ($urandom_range(0, 4))
        0, 1, 2: begin
          // Aim at a loaded partition: exact fit, a little under, or one over.
          s = plan_size[$urandom_range(0, PARTS - 1)];
          d = $urandom_range(0, 3);
          if ($urandom_range(0, 7) == 0 && s != 16'hFFFF)
            r.request_size = s + 16'd1;
          else
            r.request_size = (s > d) ? s - d[15:0] : 16'd0;
        end
        3: r.request_size = 16'($urandom_range(0, 400));
        default: ;
      endcase
    end else if (roll < 82) begin
      r.req_type = REQ_RELEASE;
    end else if (roll < 97) begin
      r.req_type = REQ_LOAD;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r.request_size = 16'($urandom_range(1, 400));
        4, 5:       r.request_size = plan_size[$urandom_range(0, PARTS - 1)];
        6:          r.request_size = 16'hFFFF;
        7:          r.request_size = 16'd0;
        default:    ;
      endcase
      plan_size[r.partition_index] = r.request_size;
    end else begin
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  task automatic queue_word(input req_t r);
    if (r.req_type == REQ_LOAD) plan_size[r.partition_index] = r.request_size;
    pending_words.push_back(r);
    words_queued++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cfg_t'{cfg_index: idx, cfg_value: value};
    do @(negedge clk); while (!cfg_accepted);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || grants_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin : drive_req
    logic next_valid;
    req_t next_word;
    next_valid = req_if.valid;
    next_word  = req_if.data;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!req_if.valid || req_accepted) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_words.size() != 0) begin
        next_word  = pending_words.pop_front();
        next_valid = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    req_if.valid <= next_valid;
    req_if.data  <= next_word;
  end

  // Result receiver: a changing stall pattern, plus the occasional long hold-off.
  always @(negedge clk) begin : drive_rsp_ready
    logic rdy;
    rdy = 1'b0;
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    stall_phase++;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = (stall_phase % 4 == 0);
        default: rdy = ($urandom_range(0, 7) != 0);
      endcase
    end
    rsp_if.ready <= rdy;
  end

  // Sampling at the rising edge: register writes, accepted words and results.
  always @(posedge clk) begin : watch
    rsp_t got;
    rsp_t want;
    logic bad;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, grants_due.size());
      $display("TB_ERROR");
      $finish;
    end else if (rst) begin
      req_accepted <= 1'b0;
      cfg_accepted <= 1'b0;
      cfg_count = '0;
      cfg_limit = 16'hFFFF;
      for (int i = 0; i < PARTS; i++) begin
        tbl_base[i]  = '0;
        tbl_size[i]  = '0;
        tbl_busy[i]  = 1'b0;
        tbl_owner[i] = '0;
      end
    end else begin
      req_accepted <= req_if.valid && req_if.ready;
      cfg_accepted <= cfg_if.valid && cfg_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.cfg_index)
          REG_PARTITION_COUNT: cfg_count = cfg_if.data.cfg_value[4:0];
          REG_SECTION_LIMIT:   cfg_limit = cfg_if.data.cfg_value;
          default:             ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        grants_due.push_back(predict_grant(req_if.data));
        words_taken++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (grants_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result word: status %0d index %0d base %h size %h owner %h",
                     got.status, got.granted_index, got.granted_base, got.granted_size,
                     got.prior_owner);
        end else begin
          want = grants_due.pop_front();
          bad = (got.status !== want.status) || (got.granted_index !== want.granted_index) ||
                (got.granted_base !== want.granted_base) ||
                (got.granted_size !== want.granted_size) ||
                (got.prior_owner !== want.prior_owner);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch at cycle %0d:", cycle_count);
              $display("  expected status %0d index %0d base %h size %h owner %h",
                       want.status, want.granted_index, want.granted_base,
                       want.granted_size, want.prior_owner);
              $display("  actual   status %0d index %0d base %h size %h owner %h",
                       got.status, got.granted_index, got.granted_base,
                       got.granted_size, got.prior_owner);
            end
          end
          case (want.status)
            ST_OK:      n_ok++;
            ST_TOO_BIG: n_too_big++;
            default:    n_full++;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [4:0]  phase_count [NUM_PHASES];
    logic [15:0] phase_limit [NUM_PHASES];
    int          phase_words [NUM_PHASES];
    logic [15:0] dir_size    [PARTS];
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    words_queued = 0;
    words_taken  = 0;
    cycle_count  = 0;
    errors       = 0;
    n_ok = 0;
    n_too_big = 0;
    n_full = 0;
    settings_used = 1;
    burst_left = 0;
    gap_left = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    stall_mode = 0;
    mode_left = 0;
    stall_phase = 0;
    for (int i = 0; i < PARTS; i++) plan_size[i] = '0;

    phase_count = '{5'd16, 5'd4, 5'd31, 5'd0, 5'($urandom_range(1, 16)), 5'd16, 5'd17};
    phase_limit = '{16'hFFFF, 16'($urandom), 16'd0, 16'hFFFF, 16'($urandom), 16'd2000,
                    16'hFFFF};
    phase_words = '{250, 220, 200, 40, 260, 300, 260};
    dir_size = '{16'hFFFF, 16'd100, 16'd100, 16'd0, 16'd50, 16'd200, 16'd300, 16'd100,
                 16'd5000, 16'd7, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4, 16'd1000};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An empty table: a zero-size request finds nothing, anything larger is too big.
    queue_word(make_req(REQ_ALLOC, 4'd15, 16'hFFFF, 16'd0, 8'd0));
    queue_word(make_req(REQ_ALLOC, 4'd0, 16'd0, 16'hFFFF, 8'hFF));
    queue_word(make_req(REQ_UNKNOWN, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF));
    for (int i = 0; i < PARTS; i++)
      queue_word(make_req(REQ_LOAD, i[3:0], (i == 0) ? 16'hFFFF : 16'($urandom),
                          dir_size[i], 8'($urandom)));
    wait_drained();

    write_reg(REG_PARTITION_COUNT, 16'd16);
    write_reg(REG_SECTION_LIMIT, 16'd60000);
    settings_used++;
    // The section limit refuses a size that the largest partition would hold;
    // equal sizes go to the lower index; releasing a free entry still reports its owner.
    queue_word(make_req(REQ_ALLOC, 4'd9, 16'd0, 16'hFFFF, 8'hFF));
    queue_word(make_req(REQ_ALLOC, 4'd0, 16'd0, 16'd100, 8'hFF));
    queue_word(make_req(REQ_ALLOC, 4'd0, 16'd0, 16'd100, 8'd1));
    queue_word(make_req(REQ_RELEASE, 4'd1, 16'd0, 16'd0, 8'd0));
    queue_word(make_req(REQ_RELEASE, 4'd1, 16'hFFFF, 16'hFFFF, 8'hFF));
    queue_word(make_req(REQ_ALLOC, 4'd0, 16'd0, 16'd0, 8'd77));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_PARTITION_COUNT, {11'd0, phase_count[p]});
      write_reg(REG_SECTION_LIMIT, phase_limit[p]);
      settings_used++;
      // In two phases the receiver stops for a long while so the block backs up.
      if (p == 0 || p == 5) hold_requests++;
      for (int k = 0; k < phase_words[p]; k++) queue_word(random_request());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (grants_due.size() != 0) begin
      $display("%0d expected results never arrived.", grants_due.size());
      errors += grants_due.size();
    end
    $display("Run covered %0d request words under %0d register settings.",
             words_taken, settings_used);
    $display("Results: %0d ok, %0d too big, %0d memory full; %0d mismatches.",
             n_ok, n_too_big, n_full, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- best_fit_partition_allocator.f -----
hw/rtl/bfpa_pkg.sv
hw/rtl/bfpa_chan_if.sv
hw/rtl/bfpa_ram.sv
hw/rtl/best_fit_partition_allocator.sv
bench/best_fit_partition_allocator_tb.sv
